/* sv/rti_pkg.sv */
// rti_pkg: shared widths, register indexes and stage structs for the
// ray/triangle intersection pipeline; used by every rti_* module and the top level
package rti_pkg;

  // coordinate and result formats
  localparam int CB          = 21;
  localparam int TB          = 16;
  localparam int DIST_BITS   = 20;
  localparam int WEIGHT_BITS = 17;
  localparam int COORD_FRAC  = 10;
  localparam int WEIGHT_FRAC = 16;
  localparam int TEX_SHIFT   = 16;

  // derived arithmetic widths
  localparam int MID_SHIFT = (3 * CB > 58) ? (3 * CB - 58) : 0;
  localparam int TV_W      = CB + 1;
  localparam int PP_W      = 2 * CB;
  localparam int QP_W      = 2 * CB + 1;
  localparam int PV_W      = 2 * CB + 1 - MID_SHIFT;
  localparam int QV_W      = 2 * CB + 2 - MID_SHIFT;
  localparam int DOT_W     = CB + QV_W + 2;
  localparam int DIV_STEPS = DIST_BITS;
  localparam int REM_W     = DOT_W + DIV_STEPS;
  localparam int ACC_W     = TB + WEIGHT_BITS + 3;

  // configuration port
  localparam int CFG_W     = 3 * CB;
  localparam int TEXREG_W  = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_ZERO    = 3'd0,
    REG_EDGE_ONE       = 3'd1,
    REG_EDGE_TWO       = 3'd2,
    REG_TEX_COORD_ZERO = 3'd3,
    REG_TEX_COORD_ONE  = 3'd4,
    REG_TEX_COORD_TWO  = 3'd5
  } reg_index_t;

  // geometry front end to divider
  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic                 sat;
    logic [DOT_W-1:0]     det;
    logic [DOT_W-1:0]     u;
    logic [DOT_W-1:0]     v;
    logic [DOT_W-1:0]     t;
    logic [DIST_BITS-1:0] maxd;
  } geom_t;

  // state carried through one divide step
  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic                 sat;
    logic [DOT_W-1:0]     det;
    logic [REM_W-1:0]     r_t;
    logic [REM_W-1:0]     r_u;
    logic [REM_W-1:0]     r_v;
    logic [DIV_STEPS-1:0] q_t;
    logic [DIV_STEPS-1:0] q_u;
    logic [DIV_STEPS-1:0] q_v;
    logic [DIST_BITS-1:0] maxd;
  } div_t;

  // divider to shading back end
  typedef struct packed {
    logic                   valid;
    logic                   miss;
    logic                   sat;
    logic [DIST_BITS-1:0]   dist_q;
    logic [WEIGHT_BITS-1:0] w1;
    logic [WEIGHT_BITS-1:0] w2;
    logic [DIST_BITS-1:0]   maxd;
  } quot_t;

endpackage

/* sv/rti_geom.sv */
// rti_geom: edge vectors, both cross products, the four dot products, sign
// repair and the hit window test; seven register stages; uses rti_pkg
module rti_geom (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [rti_pkg::CB-1:0] origin_x,
  input  logic signed [rti_pkg::CB-1:0] origin_y,
  input  logic signed [rti_pkg::CB-1:0] origin_z,
  input  logic signed [rti_pkg::CB-1:0] dir_x,
  input  logic signed [rti_pkg::CB-1:0] dir_y,
  input  logic signed [rti_pkg::CB-1:0] dir_z,
  input  logic [rti_pkg::DIST_BITS-1:0] range_limit,
  input  logic [rti_pkg::CFG_W-1:0]     vertex_zero,
  input  logic [rti_pkg::CFG_W-1:0]     edge_one,
  input  logic [rti_pkg::CFG_W-1:0]     edge_two,
  output rti_pkg::geom_t                geom
);
  import rti_pkg::*;

  logic signed [CB-1:0] v0 [3];
  logic signed [CB-1:0] ea [3];
  logic signed [CB-1:0] eb [3];
  logic signed [CB-1:0] org [3];
  logic signed [CB-1:0] dir [3];

  // unpack triangle and ray vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v0[k] = vertex_zero[k*CB +: CB];
      ea[k] = edge_one[k*CB +: CB];
      eb[k] = edge_two[k*CB +: CB];
    end
    org[0] = origin_x;
    org[1] = origin_y;
    org[2] = origin_z;
    dir[0] = dir_x;
    dir[1] = dir_y;
    dir[2] = dir_z;
  end

  // stage 1: origin relative to the first vertex
  logic                  s1_valid;
  logic signed [TV_W-1:0] s1_tv [3];
  logic signed [CB-1:0]   s1_dd [3];
  logic [DIST_BITS-1:0]   s1_maxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    for (int k = 0; k < 3; k++) begin
      s1_tv[k] <= TV_W'(org[k]) - TV_W'(v0[k]);
      s1_dd[k] <= dir[k];
    end
    s1_maxd <= range_limit;
  end

  // stage 2: cross product partial products
  logic                   s2_valid;
  logic signed [PP_W-1:0] s2_pp [6];
  logic signed [QP_W-1:0] s2_qp [6];
  logic signed [TV_W-1:0] s2_tv [3];
  logic signed [CB-1:0]   s2_dd [3];
  logic [DIST_BITS-1:0]   s2_maxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_pp[0] <= s1_dd[1] * eb[2];
    s2_pp[1] <= s1_dd[2] * eb[1];
    s2_pp[2] <= s1_dd[2] * eb[0];
    s2_pp[3] <= s1_dd[0] * eb[2];
    s2_pp[4] <= s1_dd[0] * eb[1];
    s2_pp[5] <= s1_dd[1] * eb[0];
    s2_qp[0] <= s1_tv[1] * ea[2];
    s2_qp[1] <= s1_tv[2] * ea[1];
    s2_qp[2] <= s1_tv[2] * ea[0];
    s2_qp[3] <= s1_tv[0] * ea[2];
    s2_qp[4] <= s1_tv[0] * ea[1];
    s2_qp[5] <= s1_tv[1] * ea[0];
    s2_tv   <= s1_tv;
    s2_dd   <= s1_dd;
    s2_maxd <= s1_maxd;
  end

  // stage 3: cross product differences, floored right
  logic signed [PP_W:0]   pdiff [3];
  logic signed [QP_W:0]   qdiff [3];
  logic                   s3_valid;
  logic signed [PV_W-1:0] s3_pv [3];
  logic signed [QV_W-1:0] s3_qv [3];
  logic signed [TV_W-1:0] s3_tv [3];
  logic signed [CB-1:0]   s3_dd [3];
  logic [DIST_BITS-1:0]   s3_maxd;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pdiff[k] = (PP_W+1)'(s2_pp[2*k]) - (PP_W+1)'(s2_pp[2*k+1]);
      qdiff[k] = (QP_W+1)'(s2_qp[2*k]) - (QP_W+1)'(s2_qp[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    for (int k = 0; k < 3; k++) begin
      s3_pv[k] <= pdiff[k][PP_W:MID_SHIFT];
      s3_qv[k] <= qdiff[k][QP_W:MID_SHIFT];
    end
    s3_tv   <= s2_tv;
    s3_dd   <= s2_dd;
    s3_maxd <= s2_maxd;
  end

  // stage 4: dot product terms
  logic                        s4_valid;
  logic signed [CB+PV_W-1:0]   s4_md [3];
  logic signed [TV_W+PV_W-1:0] s4_mu [3];
  logic signed [CB+QV_W-1:0]   s4_mv [3];
  logic signed [CB+QV_W-1:0]   s4_mt [3];
  logic [DIST_BITS-1:0]        s4_maxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    for (int k = 0; k < 3; k++) begin
      s4_md[k] <= ea[k] * s3_pv[k];
      s4_mu[k] <= s3_tv[k] * s3_pv[k];
      s4_mv[k] <= s3_dd[k] * s3_qv[k];
      s4_mt[k] <= eb[k] * s3_qv[k];
    end
    s4_maxd <= s3_maxd;
  end

  // stage 5: dot product sums
  logic                    s5_valid;
  logic signed [DOT_W-1:0] s5_det, s5_u, s5_v, s5_t;
  logic [DIST_BITS-1:0]    s5_maxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_det  <= DOT_W'(s4_md[0]) + DOT_W'(s4_md[1]) + DOT_W'(s4_md[2]);
    s5_u    <= DOT_W'(s4_mu[0]) + DOT_W'(s4_mu[1]) + DOT_W'(s4_mu[2]);
    s5_v    <= DOT_W'(s4_mv[0]) + DOT_W'(s4_mv[1]) + DOT_W'(s4_mv[2]);
    s5_t    <= DOT_W'(s4_mt[0]) + DOT_W'(s4_mt[1]) + DOT_W'(s4_mt[2]);
    s5_maxd <= s4_maxd;
  end

  // stage 6: make the determinant positive
  logic                    s6_valid;
  logic signed [DOT_W-1:0] s6_det, s6_u, s6_v, s6_t;
  logic [DIST_BITS-1:0]    s6_maxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    if (s5_det[DOT_W-1]) begin
      s6_det <= -s5_det;
      s6_u   <= -s5_u;
      s6_v   <= -s5_v;
      s6_t   <= -s5_t;
    end else begin
      s6_det <= s5_det;
      s6_u   <= s5_u;
      s6_v   <= s5_v;
      s6_t   <= s5_t;
    end
    s6_maxd <= s5_maxd;
  end

  // stage 7: inside test, positive distance, distance overflow
  logic signed [DOT_W:0]              uv_sum;
  logic [DOT_W+COORD_FRAC-1:0]        det_scaled;
  logic                               miss_c;

  always_comb begin
    uv_sum     = (DOT_W+1)'(s6_u) + (DOT_W+1)'(s6_v);
    det_scaled = {s6_det, COORD_FRAC'(0)};
    miss_c     = (s6_det == '0) || s6_u[DOT_W-1] || s6_v[DOT_W-1] ||
                 (uv_sum > (DOT_W+1)'(s6_det)) || s6_t[DOT_W-1] || (s6_t == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.valid <= 1'b0;
    end else begin
      geom.valid <= s6_valid;
    end
    geom.miss <= miss_c;
    geom.sat  <= (DOT_W+COORD_FRAC)'(s6_t) >= det_scaled;
    geom.det  <= s6_det;
    geom.u    <= s6_u;
    geom.v    <= s6_v;
    geom.t    <= s6_t;
    geom.maxd <= s6_maxd;
  end

endmodule

/* sv/rti_div_step.sv */
// rti_div_step: one registered restoring-division step for the distance and
// both weight quotients against a shared divisor; uses rti_pkg
module rti_div_step (
  input  logic          clk,
  input  logic          rst,
  input  rti_pkg::div_t din,
  output rti_pkg::div_t dout
);
  import rti_pkg::*;

  logic [REM_W-1:0] dtop;
  logic             ge_t, ge_u, ge_v;
  logic [REM_W-1:0] rt, ru, rv;

  // compare each remainder with the aligned divisor
  always_comb begin
    dtop = {1'b0, din.det, (DIV_STEPS-1)'(0)};
    ge_t = din.r_t >= dtop;
    ge_u = din.r_u >= dtop;
    ge_v = din.r_v >= dtop;
    rt   = ge_t ? (din.r_t - dtop) : din.r_t;
    ru   = ge_u ? (din.r_u - dtop) : din.r_u;
    rv   = ge_v ? (din.r_v - dtop) : din.r_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.miss <= din.miss;
    dout.sat  <= din.sat;
    dout.det  <= din.det;
    dout.maxd <= din.maxd;
    dout.r_t  <= {rt[REM_W-2:0], 1'b0};
    dout.r_u  <= {ru[REM_W-2:0], 1'b0};
    dout.r_v  <= {rv[REM_W-2:0], 1'b0};
    dout.q_t  <= {din.q_t[DIV_STEPS-2:0], ge_t};
    dout.q_u  <= {din.q_u[DIV_STEPS-2:0], ge_u};
    dout.q_v  <= {din.q_v[DIV_STEPS-2:0], ge_v};
  end

endmodule

/* sv/rti_divider.sv */
// rti_divider: chain of rti_div_step stages giving floor(t*2^10/det) and
// floor(u*2^16/det), floor(v*2^16/det); uses rti_pkg and rti_div_step
module rti_divider (
  input  logic           clk,
  input  logic           rst,
  input  rti_pkg::geom_t geom,
  output rti_pkg::quot_t quot
);
  import rti_pkg::*;

  div_t chain [DIV_STEPS+1];

  // scaled numerators enter the first step
  always_comb begin
    chain[0].valid = geom.valid;
    chain[0].miss  = geom.miss;
    chain[0].sat   = geom.sat;
    chain[0].det   = geom.det;
    chain[0].maxd  = geom.maxd;
    chain[0].r_t   = REM_W'(geom.t) << COORD_FRAC;
    chain[0].r_u   = REM_W'(geom.u) << WEIGHT_FRAC;
    chain[0].r_v   = REM_W'(geom.v) << WEIGHT_FRAC;
    chain[0].q_t   = '0;
    chain[0].q_u   = '0;
    chain[0].q_v   = '0;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    rti_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // quotients out
  always_comb begin
    quot.valid  = chain[DIV_STEPS].valid;
    quot.miss   = chain[DIV_STEPS].miss;
    quot.sat    = chain[DIV_STEPS].sat;
    quot.maxd   = chain[DIV_STEPS].maxd;
    quot.dist_q = chain[DIV_STEPS].q_t[DIST_BITS-1:0];
    quot.w1     = chain[DIV_STEPS].q_u[WEIGHT_BITS-1:0];
    quot.w2     = chain[DIV_STEPS].q_v[WEIGHT_BITS-1:0];
  end

endmodule

/* sv/rti_shade.sv */
// rti_shade: range check against the maximum distance, third weight, texture
// interpolation with rounding and saturation, output register; uses rti_pkg
module rti_shade (
  input  logic                             clk,
  input  logic                             rst,
  input  rti_pkg::quot_t                   quot,
  input  logic [rti_pkg::TEXREG_W-1:0]     tex_coord_zero,
  input  logic [rti_pkg::TEXREG_W-1:0]     tex_coord_one,
  input  logic [rti_pkg::TEXREG_W-1:0]     tex_coord_two,
  output logic                             done,
  output logic                             hit,
  output logic [rti_pkg::DIST_BITS-1:0]    distance,
  output logic [rti_pkg::WEIGHT_BITS-1:0]  weight_one,
  output logic [rti_pkg::WEIGHT_BITS-1:0]  weight_two,
  output logic signed [rti_pkg::TB-1:0]    tex_u,
  output logic signed [rti_pkg::TB-1:0]    tex_v
);
  import rti_pkg::*;

  localparam logic [WEIGHT_BITS-1:0] ONE_W = WEIGHT_BITS'(1) << WEIGHT_FRAC;
  localparam int                     PR_W  = TB + WEIGHT_BITS + 1;

  logic [DIST_BITS-1:0]   dist_c;
  logic [WEIGHT_BITS-1:0] w0_c;
  logic signed [TB-1:0]   tu [3];
  logic signed [TB-1:0]   tv [3];
  logic signed [WEIGHT_BITS:0] ws [3];

  // saturated distance and third weight
  always_comb begin
    dist_c = quot.sat ? '1 : quot.dist_q;
    w0_c   = ONE_W - quot.w1 - quot.w2;
    tu[0]  = tex_coord_zero[TB-1:0];
    tu[1]  = tex_coord_one[TB-1:0];
    tu[2]  = tex_coord_two[TB-1:0];
    tv[0]  = tex_coord_zero[2*TB-1:TB];
    tv[1]  = tex_coord_one[2*TB-1:TB];
    tv[2]  = tex_coord_two[2*TB-1:TB];
    ws[0]  = {1'b0, w0_c};
    ws[1]  = {1'b0, quot.w1};
    ws[2]  = {1'b0, quot.w2};
  end

  // stage a: texture products
  logic                   a_valid;
  logic                   a_hit;
  logic [DIST_BITS-1:0]   a_dist;
  logic [WEIGHT_BITS-1:0] a_w1, a_w2;
  logic signed [PR_W-1:0] a_pu [3];
  logic signed [PR_W-1:0] a_pv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= quot.valid;
    end
    a_hit  <= !quot.miss && (dist_c < quot.maxd);
    a_dist <= dist_c;
    a_w1   <= quot.w1;
    a_w2   <= quot.w2;
    for (int k = 0; k < 3; k++) begin
      a_pu[k] <= tu[k] * ws[k];
      a_pv[k] <= tv[k] * ws[k];
    end
  end

  // stage b: sum, round half up, saturate
  localparam int RS_W = ACC_W - TEX_SHIFT;
  localparam logic signed [RS_W-1:0] TEX_HI = RS_W'((1 << (TB - 1)) - 1);
  localparam logic signed [RS_W-1:0] TEX_LO = -TEX_HI - RS_W'(1);

  logic signed [ACC_W-1:0] acc_u, acc_v;
  logic signed [RS_W-1:0]  rs_u, rs_v;
  logic signed [TB-1:0]    sat_u, sat_v;

  always_comb begin
    acc_u = ACC_W'(a_pu[0]) + ACC_W'(a_pu[1]) + ACC_W'(a_pu[2]) +
            ACC_W'(1 << (TEX_SHIFT - 1));
    acc_v = ACC_W'(a_pv[0]) + ACC_W'(a_pv[1]) + ACC_W'(a_pv[2]) +
            ACC_W'(1 << (TEX_SHIFT - 1));
    rs_u  = acc_u[ACC_W-1:TEX_SHIFT];
    rs_v  = acc_v[ACC_W-1:TEX_SHIFT];
    if (rs_u > TEX_HI) begin
      sat_u = TB'(TEX_HI);
    end else if (rs_u < TEX_LO) begin
      sat_u = TB'(TEX_LO);
    end else begin
      sat_u = rs_u[TB-1:0];
    end
    if (rs_v > TEX_HI) begin
      sat_v = TB'(TEX_HI);
    end else if (rs_v < TEX_LO) begin
      sat_v = TB'(TEX_LO);
    end else begin
      sat_v = rs_v[TB-1:0];
    end
  end

  // result register, all zero on a miss
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    hit        <= a_hit;
    distance   <= a_hit ? a_dist : '0;
    weight_one <= a_hit ? a_w1 : '0;
    weight_two <= a_hit ? a_w2 : '0;
    tex_u      <= a_hit ? sat_u : '0;
    tex_v      <= a_hit ? sat_v : '0;
  end

endmodule

/* sv/ray_triangle_intersect.sv */
// ray_triangle_intersect: top level, triangle configuration registers and
// the geometry, divider and shading pipeline; uses rti_pkg and rti_* modules
//
// Usage
//   Configuration: write cfg_data into register cfg_index when cfg_write is
//   high (0 vertex_zero, 1 edge_one, 2 edge_two, 3..5 tex_coord_zero..two).
//   Write only while no ray is in flight; other indexes are ignored.
//   Rays: a ray transfer happens at each clock edge with start high and
//   busy low. busy is always low, so one ray can enter every cycle.
//   Results: done rises with each result, once the ray has passed the
//   geometry, divider and shading registers; hit, distance, weight_one,
//   weight_two, tex_u and tex_v are valid while done is high and every
//   field is zero on a miss. Results leave in ray order and the receiver
//   cannot stall them.
//   Stages: 7 geometry stages (vectors, cross products, dot products, sign
//   repair, window test), 20 restoring-division steps (one quotient bit per
//   step for all three quotients) and 2 texture stages.
//   Throughput: one ray per cycle, set by the fully pipelined datapath.
//   Reset: rst clears the configuration registers and all stage valid bits;
//   rays in flight are dropped and produce no result.
module ray_triangle_intersect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_write,
  input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rti_pkg::CFG_W-1:0]        cfg_data,
  input  logic signed [rti_pkg::CB-1:0]    origin_x,
  input  logic signed [rti_pkg::CB-1:0]    origin_y,
  input  logic signed [rti_pkg::CB-1:0]    origin_z,
  input  logic signed [rti_pkg::CB-1:0]    dir_x,
  input  logic signed [rti_pkg::CB-1:0]    dir_y,
  input  logic signed [rti_pkg::CB-1:0]    dir_z,
  input  logic [rti_pkg::DIST_BITS-1:0]    range_limit,
  output logic                             done,
  output logic                             hit,
  output logic [rti_pkg::DIST_BITS-1:0]    distance,
  output logic [rti_pkg::WEIGHT_BITS-1:0]  weight_one,
  output logic [rti_pkg::WEIGHT_BITS-1:0]  weight_two,
  output logic signed [rti_pkg::TB-1:0]    tex_u,
  output logic signed [rti_pkg::TB-1:0]    tex_v
);
  import rti_pkg::*;

  logic [CFG_W-1:0]    vertex_zero, edge_one, edge_two;
  logic [TEXREG_W-1:0] tex_coord_zero, tex_coord_one, tex_coord_two;
  geom_t               geom;
  quot_t               quot;

  // pipeline never holds off a ray
  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_zero    <= '0;
      edge_one       <= '0;
      edge_two       <= '0;
      tex_coord_zero <= '0;
      tex_coord_one  <= '0;
      tex_coord_two  <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_VERTEX_ZERO:    vertex_zero    <= cfg_data;
        REG_EDGE_ONE:       edge_one       <= cfg_data;
        REG_EDGE_TWO:       edge_two       <= cfg_data;
        REG_TEX_COORD_ZERO: tex_coord_zero <= cfg_data[TEXREG_W-1:0];
        REG_TEX_COORD_ONE:  tex_coord_one  <= cfg_data[TEXREG_W-1:0];
        REG_TEX_COORD_TWO:  tex_coord_two  <= cfg_data[TEXREG_W-1:0];
        default: ;
      endcase
    end
  end

  rti_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .range_limit  (range_limit),
    .vertex_zero  (vertex_zero),
    .edge_one     (edge_one),
    .edge_two     (edge_two),
    .geom         (geom)
  );

  rti_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .geom (geom),
    .quot (quot)
  );

  rti_shade u_shade (
    .clk            (clk),
    .rst            (rst),
    .quot           (quot),
    .tex_coord_zero (tex_coord_zero),
    .tex_coord_one  (tex_coord_one),
    .tex_coord_two  (tex_coord_two),
    .done           (done),
    .hit            (hit),
    .distance       (distance),
    .weight_one     (weight_one),
    .weight_two     (weight_two),
    .tex_u          (tex_u),
    .tex_v          (tex_v)
  );

`ifndef SYNTHESIS
  // a hit never comes with both a zero distance and a zero range limit
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> distance != '0 || $past(quot.maxd, 2) != '0)
    else $error("hit outside distance range");

  // weights of a hit are convex
  a_weights_convex: assert property (@(posedge clk) disable iff (rst)
    done && hit |->
      ({1'b0, weight_one} + {1'b0, weight_two}) <= ((WEIGHT_BITS+1)'(1) << WEIGHT_FRAC))
    else $error("barycentric weights exceed one");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> distance == '0 && weight_one == '0 && weight_two == '0 &&
                     tex_u == '0 && tex_v == '0)
    else $error("miss result with nonzero fields");

  // a miss from the front end never becomes a hit
  a_miss_kept: assert property (@(posedge clk) disable iff (rst)
    quot.valid && quot.miss |=> ##1 done && !hit)
    else $error("front end miss turned into a hit");
`endif

endmodule
